/* src/rthi_pkg.sv */
// shared types and constants for the rgb to hue index converter
// no dependencies; imported by every module of the block
package rthi_pkg;

   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int HUE_W       = 11;
   localparam int NUM_W       = 2 * CHAN_W;
   localparam int DIV_STEPS   = CHAN_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CHAN_W-1:0] FULL_LEVEL = 8'hFF;
   localparam logic [HUE_W-1:0]  HUE_MAX    = 11'd1535;

   // channel that gets cleared before the sector lookup
   typedef enum logic [1:0] {
      CLR_RED   = 2'd0,
      CLR_GREEN = 2'd1,
      CLR_BLUE  = 2'd2
   } clear_sel_type;

   // classified word; acc starts as mid*255 and becomes the quotient
   typedef struct packed {
      logic [NUM_W-1:0]  acc;
      logic [CHAN_W-1:0] peak;
      clear_sel_type     clr;
      logic              r_peak;
      logic              g_peak;
      logic              b_peak;
      logic              grey;
   } hue_item_type;

endpackage

/* src/rthi_front.sv */
// front end: accepts colour words, finds peak, cleared channel and divide operand
// depends on rthi_pkg
module rthi_front
   import rthi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [COLOR_W-1:0] req_color_word,
   output logic               out_valid,
   input  logic               out_ready,
   output hue_item_type       out_item
);

   logic [CHAN_W-1:0] r, g, b;
   logic [CHAN_W-1:0] peak, low, mid;
   clear_sel_type     clr;
   hue_item_type      item;

   logic              fr_vld_ff, fr_vld_in;
   hue_item_type      fr_item_ff;

   assign r = req_color_word[7:0];
   assign g = req_color_word[15:8];
   assign b = req_color_word[23:16];

   always_comb begin
      peak = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;

      low = r;
      clr = CLR_RED;
      if (g < low) begin
         low = g;
         clr = CLR_GREEN;
      end
      if (b < low) begin
         low = b;
         clr = CLR_BLUE;
      end

      // smaller of the two channels that survive the clear
      case (clr)
         CLR_RED:   mid = (g < b) ? g : b;
         CLR_GREEN: mid = (r < b) ? r : b;
         CLR_BLUE:  mid = (r < g) ? r : g;
         default:   mid = low;
      endcase

      item.acc    = {mid, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, mid};
      item.peak   = peak;
      item.clr    = clr;
      item.r_peak = (r == peak);
      item.g_peak = (g == peak);
      item.b_peak = (b == peak);
      item.grey   = (r == g) && (g == b);
   end

   assign req_full  = fr_vld_ff && !out_ready;
   assign fr_vld_in = req_full ? fr_vld_ff : req_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else begin
         fr_vld_ff <= fr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_push && !req_full) begin
         fr_item_ff <= item;
      end
   end

   assign out_valid = fr_vld_ff;
   assign out_item  = fr_item_ff;

endmodule

/* src/rthi_queue.sv */
// short register queue between the front end and the divide pipeline
// depends on rthi_pkg
module rthi_queue
   import rthi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  hue_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output hue_item_type out_item
);

   hue_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   cnt_ff, cnt_in;
   logic                   push, pop;

   assign in_ready  = (cnt_ff != QUEUE_DEPTH[QUEUE_PTR_W:0]);
   assign out_valid = (cnt_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];

   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* src/rthi_back.sv */
// back end: restoring divide pipeline, one quotient bit per stage, then sector map
// depends on rthi_pkg
module rthi_back
   import rthi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hue_item_type      in_item,
   output logic              out_empty,
   input  logic              out_pop,
   output logic [HUE_W-1:0]  out_hue_index,
   output logic [CHAN_W-1:0] out_intensity_level
);

   // acc holds {remainder, numerator bits left, quotient bits so far}
   function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] acc,
                                                 input logic [CHAN_W-1:0] div);
      logic [CHAN_W:0] t;
      logic [CHAN_W:0] diff;
      logic            ge;
      logic [CHAN_W-1:0] rem;
      t    = {acc[NUM_W-1:CHAN_W], acc[CHAN_W-1]};
      diff = t - {1'b0, div};
      ge   = (t >= {1'b0, div});
      rem  = ge ? diff[CHAN_W-1:0] : t[CHAN_W-1:0];
      return {rem, acc[CHAN_W-2:0], ge};
   endfunction

   function automatic logic [HUE_W-1:0] sector_map(input logic [CHAN_W-1:0] sr,
                                                   input logic [CHAN_W-1:0] sg,
                                                   input logic [CHAN_W-1:0] sb);
      logic [HUE_W-1:0] hue;
      if (sr == FULL_LEVEL && sb == '0) begin
         hue = {3'b000, sg};
      end else if (sg == FULL_LEVEL && sb == '0) begin
         hue = 11'd511 - {3'b000, sr};
      end else if (sg == FULL_LEVEL && sr == '0) begin
         hue = 11'd512 + {3'b000, sb};
      end else if (sb == FULL_LEVEL && sr == '0) begin
         hue = 11'd1023 - {3'b000, sg};
      end else if (sb == FULL_LEVEL && sg == '0) begin
         hue = 11'd1024 + {3'b000, sr};
      end else if (sr == FULL_LEVEL && sg == '0) begin
         hue = HUE_MAX - {3'b000, sb};
      end else begin
         hue = '0;
      end
      return hue;
   endfunction

   hue_item_type          st_ff  [DIV_STEPS];
   hue_item_type          st_in  [DIV_STEPS];
   logic [DIV_STEPS-1:0]  vld_ff, vld_in;
   logic [DIV_STEPS-1:0]  adv;
   logic                  out_adv;

   logic                  out_vld_ff, out_vld_in;
   logic [HUE_W-1:0]      out_hue_ff, out_hue_in;
   logic [CHAN_W-1:0]     out_level_ff;

   hue_item_type          last;
   logic [CHAN_W-1:0]     quot;
   logic [CHAN_W-1:0]     sr, sg, sb;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      out_adv = !out_vld_ff || out_pop;
      adv[DIV_STEPS-1] = !vld_ff[DIV_STEPS-1] || out_adv;
      for (int k = DIV_STEPS - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      st_in[0]     = in_item;
      st_in[0].acc = div_step(in_item.acc, in_item.peak);
      vld_in[0]    = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < DIV_STEPS; k++) begin
         st_in[k]     = st_ff[k-1];
         st_in[k].acc = div_step(st_ff[k-1].acc, st_ff[k-1].peak);
         vld_in[k]    = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // peak channel scales to full, cleared one to zero, the other to the quotient
   always_comb begin
      last = st_ff[DIV_STEPS-1];
      quot = last.acc[CHAN_W-1:0];
      sr   = (last.clr == CLR_RED)   ? '0 : (last.r_peak ? FULL_LEVEL : quot);
      sg   = (last.clr == CLR_GREEN) ? '0 : (last.g_peak ? FULL_LEVEL : quot);
      sb   = (last.clr == CLR_BLUE)  ? '0 : (last.b_peak ? FULL_LEVEL : quot);
      out_hue_in = last.grey ? '0 : sector_map(sr, sg, sb);
      out_vld_in = out_adv ? vld_ff[DIV_STEPS-1] : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_hue_ff   <= out_hue_in;
         out_level_ff <= last.peak;
      end
   end

   assign out_empty           = !out_vld_ff;
   assign out_hue_index       = out_hue_ff;
   assign out_intensity_level = out_level_ff;

endmodule

/* src/rgb_to_hue_index_top.sv */
// channel   dir  handshake                  payload
// req       in   req_push / req_full        req_color_word[23:0]
// rsp       out  rsp_empty / rsp_pop        rsp_hue_index[10:0], rsp_intensity_level[7:0]
//
// one word per cycle sustained while rsp_pop keeps up; each word passes, in order:
// front register, queue, eight divide stages (one quotient bit each), output register
// synchronous reset empties every stage; req_full is low the cycle after reset
// a stalled result side fills the divide pipeline, then the queue, then raises req_full
//
// top level of the rgb to hue index converter
// depends on rthi_pkg, rthi_front, rthi_queue, rthi_back
module rgb_to_hue_index_top
   import rthi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [COLOR_W-1:0] req_color_word,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [HUE_W-1:0]   rsp_hue_index,
   output logic [CHAN_W-1:0]  rsp_intensity_level
);

   logic         fr_valid, fr_ready;
   hue_item_type fr_item;
   logic         q_valid, q_ready;
   hue_item_type q_item;

   rthi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_color_word (req_color_word),
      .out_valid      (fr_valid),
      .out_ready      (fr_ready),
      .out_item       (fr_item)
   );

   rthi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   rthi_back u_back (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (q_valid),
      .in_ready            (q_ready),
      .in_item             (q_item),
      .out_empty           (rsp_empty),
      .out_pop             (rsp_pop),
      .out_hue_index       (rsp_hue_index),
      .out_intensity_level (rsp_intensity_level)
   );

`ifndef SYNTHESIS
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_hue_index <= HUE_MAX)
      else $error("hue index beyond wheel");

   a_black_hue: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_intensity_level == '0) |-> rsp_hue_index == '0)
      else $error("black word with nonzero hue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input side full after reset");
`endif

endmodule
